// File: rtl/core/msrl_pkg.sv
// ----------------------------------------------------------------------------
// msrl_pkg
// Shared types and constants for the relative error loss block.
// ----------------------------------------------------------------------------
package msrl_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IGN_LOW  = 3'd0,
    REG_IGN_HIGH = 3'd1,
    REG_EPSILON  = 3'd2,
    REG_BATCH    = 3'd3,
    REG_WEIGHT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ALPHA,
    ST_TERM,
    ST_ACC,
    ST_GP,
    ST_GPFIX,
    ST_MUL,
    ST_GT,
    ST_LOSS,
    ST_DONE
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        sat;
    logic [63:0] quo;
  } div_rsp_t;

  localparam logic [63:0] HoldMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [46:0] LossMax = {47{1'b1}};

endpackage

// File: rtl/core/msrl_div.sv
// ----------------------------------------------------------------------------
// msrl_div
// Bit-serial restoring divider, 128 by 64 bits, one quotient bit per cycle.
// Quotient saturates to all ones when it would not fit in 64 bits.
// ----------------------------------------------------------------------------
module msrl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msrl_pkg::div_req_t req_i,
  output msrl_pkg::div_rsp_t rsp_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] lo_q, lo_d;
  logic [63:0] den_q, den_d;
  logic [63:0] quo_q, quo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        sat_q, sat_d;
  logic [64:0] shifted;
  logic        take;

  assign shifted = {rem_q, lo_q[63]};
  assign take    = shifted[64] || (shifted[63:0] >= den_q);

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    if (req_i.start) begin
      rem_d = req_i.num[127:64];
      lo_d  = req_i.num[63:0];
      den_d = req_i.den;
      quo_d = '0;
      cnt_d = 7'd64;
      if (req_i.num[127:64] >= req_i.den) begin
        sat_d  = 1'b1;
        quo_d  = '1;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        sat_d  = 1'b0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = take ? (shifted[63:0] - den_q) : shifted[63:0];
      lo_d  = {lo_q[62:0], 1'b0};
      quo_d = {quo_q[62:0], take};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.quo  = quo_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q || $past(req_i.start))
    else $error("divider done held");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0)
    else $error("divider busy with zero count");
  a_sat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && sat_q) |-> quo_q == '1)
    else $error("saturated quotient not all ones");

endmodule

// File: rtl/core/msrl_mul.sv
// ----------------------------------------------------------------------------
// msrl_mul
// Bit-serial shift-add multiplier, 64 by 64 to 128 bits, one bit per cycle.
// ----------------------------------------------------------------------------
module msrl_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0] a_q, a_d;
  logic [64:0] hi_q, hi_d;
  logic [63:0] lo_q, lo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] part;

  // add the multiplicand when the current multiplier bit (lsb of lo) is set
  assign part = hi_q + (lo_q[0] ? {1'b0, a_q} : 65'd0);

  always_comb begin
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = {1'b0, part[64:1]};
      lo_d  = {part[0], lo_q[63:1]};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[63:0], lo_q};

  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0)
    else $error("multiplier busy with zero count");
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("multiplier done while busy");
  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == 7'd64)
    else $error("multiplier did not start");

endmodule

// File: rtl/core/mean_squared_relative_loss.sv
// ----------------------------------------------------------------------------
// mean_squared_relative_loss
// Streaming mean squared relative error loss with prediction/target gradients.
// ----------------------------------------------------------------------------
// Usage: one input beat (pred_i, target_i, last_i) on valid/stall gives one
// output beat with both gradients, flags, and on the last beat of a batch
// the batch loss (loss_valid_o = 1), after which the running sum clears.
// One item is worked at a time. A shared bit-serial divider (one quotient
// bit per cycle) and a bit-serial multiplier (one bit per cycle) do all
// wide arithmetic: alpha, the loss term, the prediction gradient, the
// product for the target gradient, the target gradient and, on last, the
// loss, worked in that order. When the denominator is zero, only alpha
// and, on last, the loss are divided. The next beat is taken only once the
// result has left and the block is back in idle. in_stall_o is high after
// acceptance until the block returns to idle after the result leaves. When
// the receiver stalls, the result holds on the output ports and no new item
// is taken. Reset clears the running sum, restores register defaults and
// empties the output. The configuration port takes a write on any cycle
// with cfg_we_i high.
// ----------------------------------------------------------------------------
module mean_squared_relative_loss #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pred_i,
  input  logic [31:0] target_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] grad_pred_o,
  output logic [31:0] grad_target_o,
  output logic [46:0] loss_o,
  output logic        loss_valid_o,
  output logic        saturated_o,
  output logic        zero_denominator_o
);

  // configuration
  logic signed [31:0] ign_low_q, ign_high_q, weight_q;
  logic [30:0]        eps_q;
  logic [15:0]        batch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_low_q  <= 32'sd1;
      ign_high_q <= 32'sd0;
      eps_q      <= 31'd1;
      batch_q    <= 16'd1;
      weight_q   <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (msrl_pkg::cfg_reg_e'(cfg_idx_i))
        msrl_pkg::REG_IGN_LOW:  ign_low_q  <= cfg_data_i;
        msrl_pkg::REG_IGN_HIGH: ign_high_q <= cfg_data_i;
        msrl_pkg::REG_EPSILON:  eps_q      <= cfg_data_i[30:0];
        msrl_pkg::REG_BATCH:    batch_q    <= cfg_data_i[15:0];
        msrl_pkg::REG_WEIGHT:   weight_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  msrl_pkg::state_e state_q, state_d;

  logic signed [31:0] y_q, t_q;
  logic               last_q;
  logic [63:0]        den_q, dm_q, am_q, pm_q, gpm_q;
  logic               dneg_q, aneg_q, pneg_q, zden_q, sat_q;
  logic [63:0]        sum_q;
  logic [31:0]        gp_q, gt_q;
  logic [46:0]        loss_q;
  logic               out_valid_q;

  msrl_pkg::div_req_t div_req;
  msrl_pkg::div_rsp_t div_rsp;
  logic               mul_start, mul_done;
  logic [127:0]       prod;

  msrl_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  msrl_mul u_mul (.clk_i, .rst_ni, .start_i(mul_start), .a_i(gpm_q), .b_i(pm_q),
                  .done_o(mul_done), .prod_o(prod));

  logic        in_acc;
  logic [15:0] bs;
  logic [64:0] sum_add;
  logic        gneg, tneg;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign bs      = (batch_q == 16'd0) ? 16'd1 : batch_q;
  assign sum_add = {1'b0, sum_q} + {1'b0, div_rsp.quo};
  assign gneg    = aneg_q ^ dneg_q;
  assign tneg    = !gneg ^ pneg_q;

  // prep arithmetic, on registered inputs (narrow 32x32 products)
  logic signed [63:0] tt, yt, pp;
  logic signed [32:0] dd;
  logic [63:0]        epsf;
  logic               in_win;
  assign epsf   = 64'(eps_q) << FRAC_BITS;
  assign tt     = t_q * t_q;
  assign yt     = y_q * t_q;
  assign pp     = yt + $signed(epsf);
  assign dd     = 33'(y_q) - 33'(t_q);
  assign in_win = (ign_low_q <= ign_high_q) && (ign_low_q <= t_q) && (t_q <= ign_high_q);

  // |d| fits 32 bits and |alpha| 33 bits; both products fit 64 bits
  logic [63:0] dsq, adm;
  assign dsq = 64'(dm_q[31:0]) * 64'(dm_q[31:0]);
  assign adm = 64'(am_q[32:0]) * 64'(dm_q[31:0]);

  // 32-bit saturation of sign/magnitude
  function automatic logic [32:0] sat32(input logic [63:0] mag, input logic neg);
    logic [32:0] r;
    begin
      if (neg) begin
        if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
        else r = {1'b0, 32'(64'd0 - mag)};
      end else begin
        if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
        else r = {1'b0, mag[31:0]};
      end
      return r;
    end
  endfunction

  function automatic logic [63:0] mag64(input logic signed [31:0] v);
    return v[31] ? 64'(-65'(v)) : 64'(v);
  endfunction

  logic [32:0] gp_s, gt_s;
  assign gp_s = sat32(gpm_q, gneg && gpm_q != 64'd0);
  assign gt_s = sat32(div_rsp.quo, tneg && div_rsp.quo != 64'd0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msrl_pkg::ST_IDLE:  if (in_acc) state_d = msrl_pkg::ST_PREP;
      msrl_pkg::ST_PREP:  state_d = msrl_pkg::ST_ALPHA;
      msrl_pkg::ST_ALPHA: if (div_rsp.done) state_d = zden_q ? msrl_pkg::ST_GT
                                                         : msrl_pkg::ST_TERM;
      msrl_pkg::ST_TERM:  if (div_rsp.done) state_d = msrl_pkg::ST_GP;
      msrl_pkg::ST_ACC:   state_d = msrl_pkg::ST_GP;
      msrl_pkg::ST_GP:    if (div_rsp.done) state_d = msrl_pkg::ST_GPFIX;
      msrl_pkg::ST_GPFIX: state_d = msrl_pkg::ST_MUL;
      msrl_pkg::ST_MUL:   if (mul_done) state_d = msrl_pkg::ST_GT;
      msrl_pkg::ST_GT:    if (zden_q || div_rsp.done)
                            state_d = last_q ? msrl_pkg::ST_LOSS : msrl_pkg::ST_DONE;
      msrl_pkg::ST_LOSS:  if (div_rsp.done) state_d = msrl_pkg::ST_DONE;
      msrl_pkg::ST_DONE:  if (!out_valid_q) state_d = msrl_pkg::ST_IDLE;
      default:            state_d = msrl_pkg::ST_IDLE;
    endcase
  end

  // divider/multiplier launch on entry to ALPHA, TERM, GP, MUL, GT, LOSS
  logic entering;
  assign entering = state_q != state_d;
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = den_q;
    mul_start     = 1'b0;
    if (entering) begin
      unique case (state_d)
        msrl_pkg::ST_ALPHA: begin
          div_req.start = 1'b1;
          div_req.num   = {64'd0, 64'd2 * mag64(weight_q)};
          div_req.den   = 64'(bs);
        end
        msrl_pkg::ST_TERM: begin
          div_req.start = 1'b1;
          div_req.num   = {64'd0, dsq} << FRAC_BITS;
        end
        msrl_pkg::ST_GP: begin
          div_req.start = 1'b1;
          div_req.num   = {64'd0, adm} << FRAC_BITS;
        end
        msrl_pkg::ST_MUL: mul_start = 1'b1;
        msrl_pkg::ST_GT: begin
          div_req.start = !zden_q;
          div_req.num   = prod;
        end
        msrl_pkg::ST_LOSS: begin
          div_req.start = 1'b1;
          div_req.num   = {64'd0, sum_q};
          div_req.den   = 64'(bs);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msrl_pkg::ST_IDLE;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == msrl_pkg::ST_TERM && div_rsp.done)
        sum_q <= sum_add[64] ? '1 : sum_add[63:0];
      if (state_q == msrl_pkg::ST_LOSS && div_rsp.done) sum_q <= '0;
      if (state_q == msrl_pkg::ST_GT && !last_q && (zden_q || div_rsp.done))
        out_valid_q <= 1'b1;
      if (state_q == msrl_pkg::ST_LOSS && div_rsp.done) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      y_q    <= pred_i;
      t_q    <= target_i;
      last_q <= last_i;
      sat_q  <= 1'b0;
      gp_q   <= '0;
      gt_q   <= '0;
      loss_q <= '0;
    end
    unique case (state_q)
      msrl_pkg::ST_PREP: begin
        den_q  <= 64'(tt) + epsf;
        zden_q <= (64'(tt) + epsf) == 64'd0;
        dm_q   <= in_win ? 64'd0 : (dd[32] ? 64'(-dd) : 64'(dd));
        dneg_q <= in_win ? 1'b0 : dd[32];
        pm_q   <= pp[63] ? 64'(-pp) : 64'(pp);
        pneg_q <= pp[63];
        aneg_q <= weight_q[31];
        if ((64'(tt) + epsf) == 64'd0 && sum_q == '1) sat_q <= 1'b1;
      end
      msrl_pkg::ST_ALPHA: if (div_rsp.done) am_q <= div_rsp.quo;
      msrl_pkg::ST_TERM: if (div_rsp.done) begin
        if (div_rsp.sat || sum_add[64] || sum_add[63:0] == '1) sat_q <= 1'b1;
      end
      msrl_pkg::ST_GP: if (div_rsp.done) begin
        gpm_q <= (div_rsp.quo > msrl_pkg::HoldMax) ? msrl_pkg::HoldMax : div_rsp.quo;
        if (div_rsp.sat || div_rsp.quo > msrl_pkg::HoldMax) sat_q <= 1'b1;
      end
      msrl_pkg::ST_GPFIX: begin
        gp_q <= gp_s[31:0];
        if (gp_s[32]) sat_q <= 1'b1;
      end
      msrl_pkg::ST_GT: if (!zden_q && div_rsp.done) begin
        gt_q <= gt_s[31:0];
        if (div_rsp.sat || gt_s[32]) sat_q <= 1'b1;
      end
      msrl_pkg::ST_LOSS: if (div_rsp.done) begin
        if (div_rsp.quo > 64'(msrl_pkg::LossMax)) begin
          loss_q <= msrl_pkg::LossMax;
          sat_q  <= 1'b1;
        end else begin
          loss_q <= div_rsp.quo[46:0];
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o         = state_q != msrl_pkg::ST_IDLE;
  assign out_valid_o        = out_valid_q;
  assign grad_pred_o        = gp_q;
  assign grad_target_o      = gt_q;
  assign loss_o             = loss_q;
  assign loss_valid_o       = last_q;
  assign saturated_o        = sat_q;
  assign zero_denominator_o = zden_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(gp_q))
    else $error("result changed under stall");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == msrl_pkg::ST_DONE)
    else $error("result shown while not done");
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msrl_pkg::ST_LOSS && div_rsp.done) |=> sum_q == '0)
    else $error("sum not cleared after loss");

endmodule
